@@ rtl/ird_pkg.sv @@
// ird_pkg: shared types, constants and helpers for the ir distance linearizer
// item structs, controller states and datapath command struct
// no dependencies
package ird_pkg;

    localparam int ADC_BITS  = 10;
    // 10*raw + offset always fits in four more bits than the reading
    localparam int DEN_W     = ADC_BITS + 4;
    // numerators are 18 bits, every quotient fits in 12 bits
    localparam int NUM_W     = 18;
    localparam int QUO_W     = 12;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [NUM_W-1:0] FRONT_NUM = NUM_W'(158480);
    localparam logic [NUM_W-1:0] RIGHT_NUM = NUM_W'(80640);
    localparam logic [NUM_W-1:0] LEFT_NUM  = NUM_W'(79680);
    localparam logic [6:0]       FRONT_OFS = 7'd112;
    localparam logic [6:0]       RIGHT_OFS = 7'd94;
    localparam logic [6:0]       LEFT_OFS  = 7'd28;

    localparam logic [7:0] FRONT_LO = 8'd19;
    localparam logic [7:0] FRONT_HI = 8'd151;
    localparam logic [7:0] SIDE_LO  = 8'd9;
    localparam logic [7:0] SIDE_HI  = 8'd81;
    localparam logic [7:0] DIST_BIAS = 8'd10;

    localparam logic [7:0] HELD_FRONT_RST = 8'd70;
    localparam logic [6:0] HELD_SIDE_RST  = 7'd30;

    typedef struct packed {
        logic [ADC_BITS-1:0] raw_front;
        logic [ADC_BITS-1:0] raw_right;
        logic [ADC_BITS-1:0] raw_left;
    } in_item_t;

    typedef struct packed {
        logic [7:0]        dist_front;
        logic [6:0]        dist_right;
        logic [6:0]        dist_left;
        logic signed [7:0] side_difference;
    } out_item_t;

    typedef enum logic [1:0] {
        CH_FRONT,
        CH_RIGHT,
        CH_LEFT
    } chan_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_COMMIT,
        ST_PUBLISH
    } state_t;

    typedef struct packed {
        logic  load;
        logic  div_start;
        logic  div_step;
        logic  commit;
        logic  publish;
        chan_t chan;
    } ctrl_cmd_t;

    function automatic logic [NUM_W-1:0] chan_num(input chan_t ch);
        logic [NUM_W-1:0] n;
        unique case (ch)
            CH_FRONT: n = FRONT_NUM;
            CH_RIGHT: n = RIGHT_NUM;
            default:  n = LEFT_NUM;
        endcase
        return n;
    endfunction

    function automatic logic [6:0] chan_ofs(input chan_t ch);
        logic [6:0] o;
        unique case (ch)
            CH_FRONT: o = FRONT_OFS;
            CH_RIGHT: o = RIGHT_OFS;
            default:  o = LEFT_OFS;
        endcase
        return o;
    endfunction

endpackage

@@ rtl/ird_ctrl.sv @@
// ird_ctrl: sequencer for the ir distance linearizer
// steps the shared divider over the three channels and owns the result valid
// depends on ird_pkg
module ird_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ird_pkg::ctrl_cmd_t cmd
);
    import ird_pkg::*;

    state_t            state_reg, state_next;
    chan_t             chan_reg, chan_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            chan_reg    <= CH_FRONT;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            chan_reg    <= chan_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        chan_next    = chan_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '{load: 1'b0, div_start: 1'b0, div_step: 1'b0, commit: 1'b0,
                         publish: 1'b0, chan: chan_reg};
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    chan_next  = CH_FRONT;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.div_start = 1'b1;
                step_next     = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                unique case (chan_reg)
                    CH_FRONT: begin
                        chan_next  = CH_RIGHT;
                        state_next = ST_SETUP;
                    end
                    CH_RIGHT: begin
                        chan_next  = CH_LEFT;
                        state_next = ST_SETUP;
                    end
                    default: begin
                        state_next = ST_PUBLISH;
                    end
                endcase
            end
            ST_PUBLISH: begin
                // waits only while an older result still sits in the output register
                if (out_free) begin
                    cmd.publish  = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> (!m_valid_reg || m_ready))
        else $error("result published over an untaken result");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in work");

    a_commit_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> $past(cmd.div_step))
        else $error("channel committed without a finished division");

endmodule

@@ rtl/ird_datapath.sv @@
// ird_datapath: input capture, shared restoring divider, clamp, averaging,
// held distances and output register; driven by ird_ctrl commands
// depends on ird_pkg
module ird_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  ird_pkg::ctrl_cmd_t cmd,
    input  ird_pkg::in_item_t  s_data,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    output ird_pkg::out_item_t m_data
);
    import ird_pkg::*;

    in_item_t         in_reg;
    out_item_t        out_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [7:0]       held_front_reg;
    logic [6:0]       held_right_reg;
    logic [6:0]       held_left_reg;
    logic             avg_reg;

    logic [ADC_BITS-1:0] raw_sel;
    logic [DEN_W-1:0]    den_start;
    logic [NUM_W-1:0]    num_sel;
    logic [DEN_W:0]      trial;
    logic                ge;
    logic [7:0]          lo_c, hi_c, held_sel, fresh, merged;
    logic [8:0]          sum;

    // divider setup: den = 10*raw + offset
    always_comb begin
        unique case (cmd.chan)
            CH_FRONT: raw_sel = in_reg.raw_front;
            CH_RIGHT: raw_sel = in_reg.raw_right;
            default:  raw_sel = in_reg.raw_left;
        endcase
        den_start = (DEN_W'(raw_sel) << 3) + (DEN_W'(raw_sel) << 1)
                  + DEN_W'(chan_ofs(cmd.chan));
        num_sel   = chan_num(cmd.chan);
    end

    // one quotient bit per step
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    // clamp on the quotient itself: q-10 > hi-1 and q-10 < lo+1
    always_comb begin
        unique case (cmd.chan)
            CH_FRONT: begin
                lo_c     = FRONT_LO;
                hi_c     = FRONT_HI;
                held_sel = held_front_reg;
            end
            CH_RIGHT: begin
                lo_c     = SIDE_LO;
                hi_c     = SIDE_HI;
                held_sel = {1'b0, held_right_reg};
            end
            default: begin
                lo_c     = SIDE_LO;
                hi_c     = SIDE_HI;
                held_sel = {1'b0, held_left_reg};
            end
        endcase
        if (quo_reg > QUO_W'(hi_c) + QUO_W'(DIST_BIAS) - QUO_W'(1)) begin
            fresh = hi_c;
        end else if (quo_reg < QUO_W'(lo_c) + QUO_W'(DIST_BIAS) + QUO_W'(1)) begin
            fresh = lo_c;
        end else begin
            fresh = quo_reg[7:0] - DIST_BIAS;
        end
        sum    = {1'b0, held_sel} + {1'b0, fresh};
        merged = avg_reg ? sum[8:1] : fresh;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        if (cmd.div_start) begin
            den_reg <= den_start;
            // upper numerator bits are always below the divisor
            rem_reg <= DEN_W'(num_sel[NUM_W-1:QUO_W]);
            quo_reg <= num_sel[QUO_W-1:0];
        end else if (cmd.div_step) begin
            rem_reg <= ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
        if (cmd.publish) begin
            out_reg.dist_front      <= held_front_reg;
            out_reg.dist_right      <= held_right_reg;
            out_reg.dist_left       <= held_left_reg;
            out_reg.side_difference <= {1'b0, held_left_reg} - {1'b0, held_right_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_reg        <= 1'b1;
            held_front_reg <= HELD_FRONT_RST;
            held_right_reg <= HELD_SIDE_RST;
            held_left_reg  <= HELD_SIDE_RST;
        end else begin
            if (cfg_we) begin
                avg_reg <= cfg_wdata;
            end
            if (cmd.commit) begin
                unique case (cmd.chan)
                    CH_FRONT: held_front_reg <= merged;
                    CH_RIGHT: held_right_reg <= merged[6:0];
                    default:  held_left_reg  <= merged[6:0];
                endcase
            end
        end
    end

    assign m_data = out_reg;

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cmd.commit) |-> (held_front_reg >= FRONT_LO && held_front_reg <= FRONT_HI
                               && {1'b0, held_right_reg} >= SIDE_LO
                               && {1'b0, held_right_reg} <= SIDE_HI
                               && {1'b0, held_left_reg} >= SIDE_LO
                               && {1'b0, held_left_reg} <= SIDE_HI))
        else $error("held distance outside clamp range");

endmodule

@@ rtl/ir_distance_linearizer_unit.sv @@
// ir_distance_linearizer_unit: top level of the ir distance linearizer
// instantiates ird_ctrl and ird_datapath; depends on ird_pkg
//
//   port group      dir   flow control      carries
//   s_*             in    valid / ready     in_item_t: raw front, right, left readings
//   m_*             out   valid / ready     out_item_t: three distances, left minus right
//   cfg_*           in    write enable      averaging enable bit
//
// m_valid rises after an item has run through three channels, each of them
// setup, 12 steps of the one shared restoring divider and commit, plus the publish step;
// a new item is taken only in idle, once the last one has been published.
// aresetn is synchronous: held distances go to 70/30/30, averaging on.
// an untaken result waits in the output register while the next item runs;
// only the publish step waits for it to leave.
module ir_distance_linearizer_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ird_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ird_pkg::out_item_t m_data,
    input  logic               cfg_we,
    input  logic               cfg_wdata
);
    import ird_pkg::*;

    ctrl_cmd_t cmd;

    ird_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    ird_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_data    (m_data)
    );

endmodule

@@ sim/tb_ir_distance_linearizer_unit.sv @@
`timescale 1ns / 100ps
// tb_ir_distance_linearizer_unit: self-checking bench for the ir distance linearizer
// uses ird_pkg item types; predicts every result and checks it on the m_ side

module tb_ir_distance_linearizer_unit;
    import ird_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;

    localparam int F_NUM = 158480;
    localparam int F_OFS = 112;
    localparam int R_NUM = 80640;
    localparam int R_OFS = 94;
    localparam int L_NUM = 79680;
    localparam int L_OFS = 28;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    logic      cfg_we = 1'b0;
    logic      cfg_wdata = 1'b0;

    ir_distance_linearizer_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    bit        avg_on;
    int        held_f;
    int        held_r;
    int        held_l;

    out_item_t pending_distances[$];
    int        err_count = 0;
    int        cycle_count = 0;
    bit        idle_on = 1'b1;
    bit        hold_req = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_ir_distance_linearizer_unit: errors");
        $finish;
    end

    // floor(num / (10*raw + ofs)) - 10, clamped; a negative value lands on the low code
    function automatic int reciprocal_dist(input int raw, input int num, input int ofs,
                                           input int lo, input int hi);
        int d;
        d = num / (10 * raw + ofs) - 10;
        if (d > hi - 1)
            return hi;
        if (d < lo + 1)
            return lo;
        return d;
    endfunction

    function automatic out_item_t predict_distances(input in_item_t it);
        out_item_t r;
        int        nf, nr, nl, diff;
        nf = reciprocal_dist(int'(it.raw_front), F_NUM, F_OFS, 19, 151);
        nr = reciprocal_dist(int'(it.raw_right), R_NUM, R_OFS, 9, 81);
        nl = reciprocal_dist(int'(it.raw_left), L_NUM, L_OFS, 9, 81);
        held_f = avg_on ? (held_f + nf) >> 1 : nf;
        held_r = avg_on ? (held_r + nr) >> 1 : nr;
        held_l = avg_on ? (held_l + nl) >> 1 : nl;
        diff = held_l - held_r;
        r.dist_front      = held_f[7:0];
        r.dist_right      = held_r[6:0];
        r.dist_left       = held_l[6:0];
        r.side_difference = diff[7:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [9:0] exp_v,
                               input logic signed [9:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        out_item_t want;
        if (m_valid && m_ready) begin
            if (pending_distances.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, m_data);
                err_count++;
            end else begin
                want = pending_distances.pop_front();
                check_field("dist_front", want.dist_front, m_data.dist_front);
                check_field("dist_right", want.dist_right, m_data.dist_right);
                check_field("dist_left", want.dist_left, m_data.dist_left);
                check_field("side_difference", want.side_difference,
                            m_data.side_difference);
            end
        end
    end

    // result sink: random stalls, plus one long hold when asked
    initial begin : result_sink
        int burst;
        int held;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                held = 1;
                while (held < HOLD_CYCLES) begin
                    @(negedge aclk);
                    held++;
                end
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                burst = $urandom_range(1, 19);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input in_item_t it);
        int gap;
        if (idle_on && $urandom_range(0, 2) == 0) begin
            // one to four bursts back to back so gaps reach late phases too
            gap = 0;
            repeat ($urandom_range(1, 4)) gap += $urandom_range(1, 19);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        pending_distances.push_back(predict_distances(it));
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_distances.size() != 0) @(negedge aclk);
    endtask

    // only written with the block idle
    task automatic set_averaging(input bit en);
        release_input();
        wait_drained();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= en;
        avg_on = en;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [ADC_BITS-1:0] pick_raw();
        case ($urandom_range(0, 4))
            0, 1: return ADC_BITS'($urandom_range(0, 1023));
            2:    return ADC_BITS'($urandom_range(0, 150));
            3:    return ADC_BITS'($urandom_range(350, 560));
            default: begin
                case ($urandom_range(0, 3))
                    0: return ADC_BITS'(0);
                    1: return ADC_BITS'(1);
                    2: return ADC_BITS'(1022);
                    default: return ADC_BITS'(1023);
                endcase
            end
        endcase
    endfunction

    function automatic in_item_t random_reading();
        in_item_t it;
        it.raw_front = pick_raw();
        it.raw_right = pick_raw();
        it.raw_left  = pick_raw();
        return it;
    endfunction

    function automatic in_item_t reading(input int f, input int r, input int l);
        in_item_t it;
        it.raw_front = ADC_BITS'(f);
        it.raw_right = ADC_BITS'(r);
        it.raw_left  = ADC_BITS'(l);
        return it;
    endfunction

    // averaging is on out of reset, held values start at 70/30/30
    task automatic test_reset_state();
        send_item(reading(0, 0, 0));
        send_item(reading(1023, 1023, 1023));
    endtask

    task automatic test_clamp_edges();
        set_averaging(1'b0);
        // each pair straddles a far or near clamp threshold
        send_item(reading(87, 79, 84));
        send_item(reading(88, 80, 85));
        send_item(reading(517, 393, 395));
        send_item(reading(518, 394, 396));
        send_item(reading(0, 0, 0));
        // negative distance on both side channels, front below its low clamp
        send_item(reading(1023, 1023, 1023));
        send_item(reading(1023, 0, 1023));
        send_item(reading(0, 1023, 0));
        send_item(reading(10'h155, 10'h2AA, 10'h155));
        send_item(reading(10'h2AA, 10'h155, 10'h2AA));
    endtask

    task automatic test_averaging();
        set_averaging(1'b1);
        // swing the side difference to both ends
        repeat (3) send_item(reading(0, 1023, 0));
        repeat (3) send_item(reading(1023, 0, 1023));
        repeat (2) send_item(reading(300, 300, 300));
    endtask

    task automatic test_backpressure();
        @(negedge aclk);
        hold_req = 1'b1;
        repeat (8) send_item(random_reading());
        wait (hold_req == 1'b0);
    endtask

    task automatic test_random(input bit en, input int count);
        set_averaging(en);
        repeat (count) send_item(random_reading());
    endtask

    task automatic test_no_idling(input int count);
        set_averaging(1'b0);
        idle_on = 1'b0;
        repeat (count) send_item(random_reading());
    endtask

    initial begin : run
        avg_on = 1'b1;
        held_f = 70;
        held_r = 30;
        held_l = 30;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_clamp_edges();
        test_averaging();
        test_backpressure();
        test_random(1'b1, 450);
        test_random(1'b0, 450);
        test_random(1'b1, 350);
        test_no_idling(150);

        release_input();
        wait_drained();
        repeat (60) @(posedge aclk);
        if (err_count == 0)
            $display("tb_ir_distance_linearizer_unit: clean");
        else
            $display("tb_ir_distance_linearizer_unit: errors");
        $finish;
    end

endmodule
